// ===== sv/tsp_pkg.sv =====
`default_nettype none

package tsp_pkg;

  localparam int unsigned NUM_STREAMS_DEF = 4;
  localparam int unsigned NUM_PID_REGS    = 4;
  localparam int unsigned PID_W           = 13;
  localparam int unsigned PROG_W          = 16;

  localparam logic [PID_W-1:0] PID_RESET  = 13'h1fff;
  localparam logic [7:0]       SYNC_BYTE  = 8'h47;
  localparam logic [7:0]       STUFF_BYTE = 8'hff;
  localparam logic [7:0]       PKT_PAYLOAD = 8'd184;
  localparam logic [7:0]       UNIT_START_BIT = 8'h40;
  localparam logic [1:0]       CTRL_PAYLOAD   = 2'b01;
  localparam logic [1:0]       CTRL_ADAPT     = 2'b11;

  // job queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // register map, word index
  localparam logic [2:0] REG_PROGRAM = 3'd0;
  localparam logic [2:0] REG_PID0    = 3'd1;
  localparam logic [2:0] REG_PID1    = 3'd2;
  localparam logic [2:0] REG_PID2    = 3'd3;
  localparam logic [2:0] REG_PID3    = 3'd4;

  typedef logic [PID_W-1:0] pid_t;
  typedef pid_t [NUM_PID_REGS-1:0] pid_arr_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_BAD_STREAM = 2'd1,
    STAT_NO_PROGRAM = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    JOB_DATA   = 2'd0,
    JOB_ERROR  = 2'd1,
    JOB_HEADER = 2'd2
  } job_kind_e;

  typedef enum logic [2:0] {
    ST_SYNC  = 3'd0,
    ST_HB1   = 3'd1,
    ST_HB2   = 3'd2,
    ST_HB3   = 3'd3,
    ST_ALEN  = 3'd4,
    ST_AFLAG = 3'd5,
    ST_STUFF = 3'd6,
    ST_DATA  = 3'd7
  } step_e;

  typedef struct packed {
    job_kind_e  kind;
    status_e    status;
    logic [7:0] data;
    logic       last;   // packet end on the payload byte
    logic [7:0] hb1;
    logic [7:0] hb2;
    logic [7:0] hb3;
    logic [7:0] len;    // clamped payload length
  } job_t;

endpackage

`default_nettype wire

// ===== sv/ts_packetizer_top.sv =====
`default_nettype none

// Transport stream packetizer. One payload byte request is taken per cycle on the
// slave stream while the queue has room; the first byte of a packet carries the
// program, stream index, start flag and length, and opens a 188-byte packet with
// header and adaptation stuffing. The front stage classifies each request, updates
// the per-stream continuity counters and hands a job to a 4-entry queue. The back
// stage plays each job out at one result per cycle unless the output stalls: a
// continuation byte or a rejected request gives 1 result, a packet start gives 5 to
// 8 (sync, three header bytes, up to three adaptation results, first payload byte).
// The master stream therefore sets the sustained rate: one result per cycle, with
// the queue soaking up header overhead. Output results are registered. The 0xff
// stuffing run is a single result whose repeat count tells the sender how many
// copies to send. Registers sit on the APB port: program number at 0x00, stream
// PIDs 0..3 at 0x04..0x10; write them only while the block is idle.

module ts_packetizer_top #(
  parameter int unsigned NUM_STREAMS = tsp_pkg::NUM_STREAMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // program_id[15:0], payload_len[23:16], data_byte[31:24]
  input  wire logic [3:0]  s_axis_tuser,  // stream_index[2:0], unit_start[3]
  // master stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // out_byte[7:0], repeat_count[15:8], item_done[16]
  output logic             m_axis_tlast,  // packet_end
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  // APB
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tsp_pkg::*;

  logic [15:0] prog_q;
  pid_arr_t    pid_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  logic        q_full, push, job_valid, pop;
  job_t        push_job, head_job;
  logic [7:0]  out_byte, repeat_count;
  logic        item_done;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= '0;
      for (int i = 0; i < int'(NUM_PID_REGS); i++) begin
        pid_q[i] <= PID_RESET;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PROGRAM: prog_q   <= pwdata[15:0];
        REG_PID0:    pid_q[0] <= pwdata[PID_W-1:0];
        REG_PID1:    pid_q[1] <= pwdata[PID_W-1:0];
        REG_PID2:    pid_q[2] <= pwdata[PID_W-1:0];
        REG_PID3:    pid_q[3] <= pwdata[PID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PROGRAM: prdata = {16'h0000, prog_q};
      REG_PID0:    prdata = {19'h0, pid_q[0]};
      REG_PID1:    prdata = {19'h0, pid_q[1]};
      REG_PID2:    prdata = {19'h0, pid_q[2]};
      REG_PID3:    prdata = {19'h0, pid_q[3]};
      default:     prdata = '0;
    endcase
  end

  tsp_front #(
    .NUM_STREAMS(NUM_STREAMS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .req_valid_i      (s_axis_tvalid),
    .req_ready_o      (s_axis_tready),
    .program_id_i     (s_axis_tdata[15:0]),
    .stream_index_i   (s_axis_tuser[2:0]),
    .unit_start_i     (s_axis_tuser[3]),
    .payload_len_i    (s_axis_tdata[23:16]),
    .data_byte_i      (s_axis_tdata[31:24]),
    .program_number_i (prog_q),
    .pids_i           (pid_q),
    .q_full_i         (q_full),
    .push_o           (push),
    .job_o            (push_job)
  );

  tsp_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .job_o      (head_job)
  );

  tsp_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i    (job_valid),
    .job_i          (head_job),
    .pop_o          (pop),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .out_byte_o     (out_byte),
    .repeat_count_o (repeat_count),
    .packet_end_o   (m_axis_tlast),
    .item_done_o    (item_done),
    .status_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0000000, item_done, repeat_count, out_byte};

endmodule

`default_nettype wire

// ===== sv/tsp_front.sv =====
`default_nettype none

module tsp_front #(
  parameter int unsigned NUM_STREAMS = tsp_pkg::NUM_STREAMS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        req_valid_i,
  output logic                             req_ready_o,
  input  wire logic [15:0]                 program_id_i,
  input  wire logic [2:0]                  stream_index_i,
  input  wire logic                        unit_start_i,
  input  wire logic [7:0]                  payload_len_i,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic [15:0]                 program_number_i,
  input  wire tsp_pkg::pid_arr_t           pids_i,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output tsp_pkg::job_t                    job_o
);
  import tsp_pkg::*;

  localparam int unsigned IdxW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  logic [7:0] remain_q, remain_d;
  logic [3:0] cc_q [NUM_STREAMS];
  logic       cc_we;
  logic [IdxW-1:0] sidx;
  logic [3:0] cc_cur;
  logic [7:0] len;
  pid_t       pid;
  logic [1:0] ctrl;
  logic       accept;

  assign req_ready_o = !q_full_i;
  assign accept      = req_valid_i && !q_full_i;
  assign push_o      = accept;
  assign sidx        = stream_index_i[IdxW-1:0];
  assign cc_cur      = cc_q[sidx];
  assign pid         = pids_i[stream_index_i[1:0]];

  always_comb begin
    len = payload_len_i;
    if (len == 8'd0) begin
      len = 8'd1;
    end else if (len > PKT_PAYLOAD) begin
      len = PKT_PAYLOAD;
    end
  end

  assign ctrl = (len < PKT_PAYLOAD) ? CTRL_ADAPT : CTRL_PAYLOAD;

  always_comb begin
    remain_d   = remain_q;
    cc_we      = 1'b0;
    job_o      = '0;
    job_o.kind = JOB_DATA;
    job_o.status = STAT_OK;
    job_o.data = data_byte_i;
    job_o.len  = len;
    job_o.hb1  = (unit_start_i ? UNIT_START_BIT : 8'h00) | {3'b000, pid[12:8]};
    job_o.hb2  = pid[7:0];
    job_o.hb3  = {2'b00, ctrl, cc_cur};
    if (remain_q != 8'd0) begin
      remain_d   = remain_q - 8'd1;
      job_o.last = (remain_q == 8'd1);
    end else if (int'(stream_index_i) >= int'(NUM_STREAMS)) begin
      job_o.kind   = JOB_ERROR;
      job_o.status = STAT_BAD_STREAM;
    end else if (program_id_i != program_number_i) begin
      job_o.kind   = JOB_ERROR;
      job_o.status = STAT_NO_PROGRAM;
    end else begin
      job_o.kind = JOB_HEADER;
      job_o.last = (len == 8'd1);
      remain_d   = len - 8'd1;
      cc_we      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      for (int i = 0; i < int'(NUM_STREAMS); i++) begin
        cc_q[i] <= '0;
      end
    end else if (accept) begin
      remain_q <= remain_d;
      if (cc_we) begin
        cc_q[sidx] <= cc_cur + 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tsp_queue.sv =====
`default_nettype none

module tsp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tsp_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output tsp_pkg::job_t      job_o
);
  import tsp_pkg::*;

  job_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tsp_back.sv =====
`default_nettype none

module tsp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire tsp_pkg::job_t job_i,
  output logic               pop_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [7:0]         repeat_count_o,
  output logic               packet_end_o,
  output logic               item_done_o,
  output logic [1:0]         status_o
);
  import tsp_pkg::*;

  step_e      step_q, step_d;
  logic       adv;
  logic       final_res;
  logic [7:0] byte_d, rep_d;
  logic       end_d;

  logic       vld_q;
  logic [7:0] byte_q, rep_q;
  logic       end_q, done_q;
  status_e    stat_q;

  assign adv = job_valid_i && (!vld_q || res_ready_i);

  always_comb begin
    step_d    = step_q;
    final_res = 1'b1;
    byte_d    = job_i.data;
    rep_d     = 8'd1;
    end_d     = 1'b0;
    unique case (job_i.kind)
      JOB_DATA: begin
        end_d = job_i.last;
      end
      JOB_ERROR: begin
        byte_d = 8'h00;
      end
      JOB_HEADER: begin
        final_res = 1'b0;
        unique case (step_q)
          ST_SYNC: begin
            byte_d = SYNC_BYTE;
            step_d = ST_HB1;
          end
          ST_HB1: begin
            byte_d = job_i.hb1;
            step_d = ST_HB2;
          end
          ST_HB2: begin
            byte_d = job_i.hb2;
            step_d = ST_HB3;
          end
          ST_HB3: begin
            byte_d = job_i.hb3;
            step_d = (job_i.len < PKT_PAYLOAD) ? ST_ALEN : ST_DATA;
          end
          ST_ALEN: begin
            byte_d = 8'd183 - job_i.len;
            step_d = (job_i.len <= 8'd182) ? ST_AFLAG : ST_DATA;
          end
          ST_AFLAG: begin
            byte_d = 8'h00;
            step_d = (job_i.len <= 8'd181) ? ST_STUFF : ST_DATA;
          end
          ST_STUFF: begin
            byte_d = STUFF_BYTE;
            rep_d  = 8'd182 - job_i.len;
            step_d = ST_DATA;
          end
          ST_DATA: begin
            end_d     = job_i.last;
            final_res = 1'b1;
            step_d    = ST_SYNC;
          end
          default: begin
            step_d = ST_SYNC;
          end
        endcase
      end
      default: begin
        byte_d = 8'h00;
      end
    endcase
  end

  assign pop_o = adv && final_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_SYNC;
      vld_q  <= 1'b0;
    end else begin
      if (adv) begin
        step_q <= step_d;
        vld_q  <= 1'b1;
      end else if (res_ready_i) begin
        vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      rep_q  <= rep_d;
      end_q  <= end_d;
      done_q <= final_res;
      stat_q <= job_i.status;
    end
  end

  assign res_valid_o    = vld_q;
  assign out_byte_o     = byte_q;
  assign repeat_count_o = rep_q;
  assign packet_end_o   = end_q;
  assign item_done_o    = done_q;
  assign status_o       = stat_q;

endmodule

`default_nettype wire

// ===== bench/ts_packetizer_checker.sv =====
`timescale 1ns / 100ps

// Watches both streams and the register port, predicts the packet bytes for
// every accepted request and compares them in order with the output stream.
module ts_packetizer_checker #(
  parameter int unsigned NUM_STREAMS = tsp_pkg::NUM_STREAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // program_id[15:0], payload_len[23:16], data_byte[31:24]
  input  logic [3:0]  s_axis_tuser,  // stream_index[2:0], unit_start[3]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // out_byte[7:0], repeat_count[15:8], item_done[16]
  input  logic        m_axis_tlast,  // packet_end
  input  logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          open_results,
  output int          checked_results
);
  import tsp_pkg::*;

  typedef struct {
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    logic       packet_end;
    logic       item_done;
    status_e    status;
  } ts_byte_t;

  ts_byte_t    pending_bytes[$];
  ts_byte_t    held;
  ts_byte_t    want;
  bit          held_valid = 1'b0;
  logic [15:0] program_num;
  pid_t        pid_tab [NUM_PID_REGS];
  logic [3:0]  cc_tab  [NUM_PID_REGS];
  logic [7:0]  payload_left;
  logic [31:0] rd_want;
  int          errs = 0;
  int          seen = 0;

  // one result is held back so the last one of a request can get item_done
  task automatic emit(input logic [7:0] b, input logic [7:0] reps, input logic pend,
                      input status_e st);
    if (held_valid) pending_bytes.push_back(held);
    held = '{b, reps, pend, 1'b0, st};
    held_valid = 1'b1;
  endtask

  task automatic predict_packet_bytes(input logic [31:0] d, input logic [3:0] u);
    logic [7:0] len;
    logic [3:0] cc;
    logic [1:0] ctrl;
    logic [1:0] sidx;
    pid_t       pid;
    len = d[23:16];
    sidx = u[1:0];
    if (payload_left != 8'd0) begin
      payload_left = payload_left - 8'd1;
      emit(d[31:24], 8'd1, payload_left == 8'd0, STAT_OK);
    end else if (u[2:0] >= NUM_STREAMS) begin
      emit(8'h00, 8'd1, 1'b0, STAT_BAD_STREAM);
    end else if (d[15:0] != program_num) begin
      emit(8'h00, 8'd1, 1'b0, STAT_NO_PROGRAM);
    end else begin
      if (len == 8'd0) len = 8'd1;
      if (len > PKT_PAYLOAD) len = PKT_PAYLOAD;
      pid = pid_tab[sidx];
      cc = cc_tab[sidx];
      cc_tab[sidx] = cc + 4'd1;
      ctrl = (len < PKT_PAYLOAD) ? CTRL_ADAPT : CTRL_PAYLOAD;
      emit(SYNC_BYTE, 8'd1, 1'b0, STAT_OK);
      emit((u[3] ? UNIT_START_BIT : 8'h00) | {3'b000, pid[12:8]}, 8'd1, 1'b0, STAT_OK);
      emit(pid[7:0], 8'd1, 1'b0, STAT_OK);
      emit({2'b00, ctrl, cc}, 8'd1, 1'b0, STAT_OK);
      // adaptation field: length byte, then flags, then one run of stuffing
      if (len < PKT_PAYLOAD) begin
        emit(PKT_PAYLOAD - 8'd1 - len, 8'd1, 1'b0, STAT_OK);
        if (len <= PKT_PAYLOAD - 8'd2) emit(8'h00, 8'd1, 1'b0, STAT_OK);
        if (len <= PKT_PAYLOAD - 8'd3)
          emit(STUFF_BYTE, PKT_PAYLOAD - 8'd2 - len, 1'b0, STAT_OK);
      end
      payload_left = len - 8'd1;
      emit(d[31:24], 8'd1, payload_left == 8'd0, STAT_OK);
    end
    held.item_done = 1'b1;
    pending_bytes.push_back(held);
    held_valid = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      program_num = '0;
      for (int i = 0; i < NUM_PID_REGS; i++) begin
        pid_tab[i] = PID_RESET;
        cc_tab[i] = 4'd0;
      end
      payload_left = 8'd0;
      held_valid = 1'b0;
      pending_bytes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected output result: out_byte %02h status %0d",
                 m_axis_tdata[7:0], m_axis_tuser);
          errs++;
        end else begin
          want = pending_bytes.pop_front();
          seen++;
          if (m_axis_tdata[7:0] !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, m_axis_tdata[7:0]);
            errs++;
          end
          if (m_axis_tdata[15:8] !== want.repeat_count) begin
            $error("repeat_count: expected %0d, got %0d", want.repeat_count,
                   m_axis_tdata[15:8]);
            errs++;
          end
          if (m_axis_tlast !== want.packet_end) begin
            $error("packet_end: expected %0b, got %0b", want.packet_end, m_axis_tlast);
            errs++;
          end
          if (m_axis_tdata[16] !== want.item_done) begin
            $error("item_done: expected %0b, got %0b", want.item_done, m_axis_tdata[16]);
            errs++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            errs++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) predict_packet_bytes(s_axis_tdata, s_axis_tuser);

      // addresses past the last register are ignored
      if (psel && penable && pready && paddr[4:2] <= REG_PID3) begin
        if (pwrite) begin
          if (paddr[4:2] == REG_PROGRAM) program_num = pwdata[PROG_W-1:0];
          else pid_tab[2'(paddr[4:2] - REG_PID0)] = pwdata[PID_W-1:0];
        end else begin
          rd_want = (paddr[4:2] == REG_PROGRAM) ? 32'(program_num)
                                                : 32'(pid_tab[2'(paddr[4:2] - REG_PID0)]);
          if (prdata !== rd_want) begin
            $error("prdata at %02h: expected %08h, got %08h", paddr, rd_want, prdata);
            errs++;
          end
        end
      end
    end
    open_results <= pending_bytes.size();
    mismatch_count <= errs;
    checked_results <= seen;
  end

endmodule

// ===== bench/ts_packetizer_top_test.sv =====
`timescale 1ns / 100ps

module ts_packetizer_top_test;
  import tsp_pkg::*;

  localparam int unsigned N_STREAMS   = NUM_STREAMS_DEF;
  localparam int unsigned SIDX_MAX    = 7;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          LATENCY_PAD = 6;
  localparam logic [2:0]  REG_SPARE   = REG_PID3 + 3'd1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // program_id[15:0], payload_len[23:16], data_byte[31:24]
  logic [3:0]  s_axis_tuser = '0;   // stream_index[2:0], unit_start[3]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // out_byte[7:0], repeat_count[15:8], item_done[16]
  logic        m_axis_tlast;        // packet_end
  logic [1:0]  m_axis_tuser;        // status[1:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int open_results;
  int checked_results;

  int send_idle_pct = 18;
  int recv_idle_pct = 57;
  int items_sent = 0;
  int packets_sent = 0;
  int rejects_sent = 0;
  int quiet_cycles = 0;
  logic [15:0] cur_program = '0;

  ts_packetizer_top #(.NUM_STREAMS(N_STREAMS)) uut (.*);

  ts_packetizer_checker #(.NUM_STREAMS(N_STREAMS)) chk (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, open_results);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drive_item(input logic [15:0] prog, input logic [2:0] sidx,
                            input logic start, input logic [7:0] len, input logic [7:0] dat);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= $urandom;
      s_axis_tuser <= 4'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {dat, len, prog};
    s_axis_tuser <= {start, sidx};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // first byte names the packet, the rest carry noise in the ignored fields
  task automatic send_packet(input logic [2:0] sidx, input logic start, input logic [7:0] len);
    int body;
    body = (len == 8'd0) ? 0 : (len > PKT_PAYLOAD) ? int'(PKT_PAYLOAD) - 1 : int'(len) - 1;
    drive_item(cur_program, sidx, start, len, 8'($urandom));
    repeat (body) drive_item(16'($urandom), 3'($urandom), 1'($urandom), 8'($urandom),
                             8'($urandom));
    packets_sent++;
  endtask

  task automatic reject_stream();
    drive_item(16'($urandom), 3'($urandom_range(SIDX_MAX, N_STREAMS)), 1'($urandom),
               8'($urandom), 8'($urandom));
    rejects_sent++;
  endtask

  task automatic reject_program();
    drive_item(cur_program ^ 16'($urandom_range(1, 16'hffff)),
               3'($urandom_range(N_STREAMS - 1)), 1'($urandom), 8'($urandom), 8'($urandom));
    rejects_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits are garbage on purpose, the block must mask them
  task automatic load_regs(input logic [15:0] prog, input pid_t p0, input pid_t p1,
                           input pid_t p2, input pid_t p3);
    apb_access(1'b1, REG_PROGRAM, {16'($urandom), prog});
    apb_access(1'b1, REG_PID0, {19'($urandom), p0});
    apb_access(1'b1, REG_PID1, {19'($urandom), p1});
    apb_access(1'b1, REG_PID2, {19'($urandom), p2});
    apb_access(1'b1, REG_PID3, {19'($urandom), p3});
    apb_access(1'b1, REG_SPARE, $urandom);
    for (int r = REG_PROGRAM; r <= REG_PID3; r++) apb_access(1'b0, 3'(r), $urandom);
    cur_program = prog;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (open_results != 0);
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  // mostly short well-formed packets, some rejects, and when asked one long packet
  task automatic run_random(input int budget, input bit with_long, input logic [7:0] long_len);
    int  base;
    int  long_at;
    int  mark;
    int  pick;
    bit  long_done;
    base = items_sent;
    long_at = $urandom_range(budget - 1);
    long_done = !with_long;
    while (items_sent - base < budget) begin
      pick = $urandom_range(99);
      if (!long_done && items_sent - base >= long_at) begin
        mark = items_sent;
        send_packet(3'($urandom_range(N_STREAMS - 1)), 1'($urandom), long_len);
        base += items_sent - mark;
        long_done = 1'b1;
      end else if (pick < 8) begin
        reject_stream();
      end else if (pick < 16) begin
        reject_program();
      end else begin
        pick = $urandom_range(99);
        send_packet(3'($urandom_range(N_STREAMS - 1)), 1'($urandom),
                    (pick < 6) ? 8'd0 :
                    (pick < 80) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(7, 40)));
      end
    end
    if (!long_done) send_packet(3'($urandom_range(N_STREAMS - 1)), 1'($urandom), long_len);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset program and PIDs
    send_packet(3'd2, 1'b1, 8'd1);
    drain();

    load_regs(16'hffff, 13'h0000, 13'h1fff, 13'h1555, 13'h0aaa);
    // stream index is checked ahead of the program
    drive_item(16'h0000, 3'd4, 1'b1, 8'd5, 8'h00);
    drive_item(cur_program, 3'd7, 1'b0, 8'd184, 8'hff);
    rejects_sent += 2;
    drive_item(16'hfffe, 3'd0, 1'b1, 8'd1, 8'hff);
    drive_item(16'h0000, 3'd3, 1'b0, 8'd2, 8'h00);
    rejects_sent += 2;
    send_packet(3'd0, 1'b1, 8'd0);
    send_packet(3'd1, 1'b0, 8'd1);
    send_packet(3'd2, 1'b1, 8'd2);
    send_packet(3'd3, 1'b1, 8'd3);
    // enough one-byte packets on stream 0 to wrap its continuity counter
    repeat (16) send_packet(3'd0, 1'($urandom), 8'd1);
    drain();

    // long packet with a short adaptation field: length byte only, or length and flags
    load_regs(16'h0000, 13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
    run_random(24, 1'b1, 8'($urandom_range(183, 182)));
    drain();

    send_idle_pct = 57;
    recv_idle_pct = 18;
    load_regs(16'($urandom), 13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
    run_random(24, 1'b0, 8'd0);
    drain();

    // full payload, no adaptation field, with oversized lengths clamped
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_regs(16'($urandom), 13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
    run_random(24, 1'b1, 8'($urandom_range(255, 184)));
    drain();

    $display("Sent %0d payload requests: %0d packets opened, %0d rejected; %0d results checked",
             items_sent, packets_sent, rejects_sent, checked_results);
    $display("Covered four register settings and three sender/receiver stall mixes");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tsp_pkg.sv
sv/tsp_front.sv
sv/tsp_queue.sv
sv/tsp_back.sv
sv/ts_packetizer_top.sv
bench/ts_packetizer_checker.sv
bench/ts_packetizer_top_test.sv
